[rtl/encoder_dial_parameter_editor_defines.svh]
// assertion helpers for the dial parameter editor
`ifndef ENCODER_DIAL_PARAMETER_EDITOR_DEFINES_SVH
`define ENCODER_DIAL_PARAMETER_EDITOR_DEFINES_SVH

// same-cycle implication, checking off while in reset
`define EDPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checking off while in reset
`define EDPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/edpe_pkg.sv]
package edpe_pkg;

    localparam int ANGLE_BITS        = 12;
    localparam int BUTTON_BITS       = 5;
    localparam int NUM_DISPLAY       = 4;
    localparam int DIAL_BIT          = 4;
    localparam int SEL_BITS          = 3;
    localparam int VALUE_BITS        = 8;
    localparam int NUM_RANGES        = 4;
    localparam int RANGE_INDEX_BITS  = 2;
    localparam int CFG_BITS          = 29;
    localparam int TURN_BITS_DEFAULT = 8;

    // range word layout
    localparam int LO_LSB   = 0;
    localparam int HI_LSB   = 8;
    localparam int SPT_LSB  = 16;
    localparam int SPT_BITS = 13;

    localparam int FULL_TURN = 1 << ANGLE_BITS;
    localparam int HALF_TURN = FULL_TURN >> 1;

    // divisor and remainder width: holds a full turn
    localparam int DIV_BITS = ANGLE_BITS + 1;

    localparam logic [SEL_BITS-1:0] SEL_NONE = SEL_BITS'(NUM_DISPLAY);

    localparam logic [CFG_BITS-1:0] RANGE_RESET [NUM_RANGES] =
        '{29'd3947521, 29'd3947526, 29'd1315584, 29'd3957781};
    localparam logic [VALUE_BITS-1:0] VALUE_RESET [NUM_RANGES] =
        '{8'd12, 8'd20, 8'd5, 8'd20};

    typedef struct packed {
        logic accept;
        logic load_dist;
        logic div_first;
        logic div_second;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic active_next;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/edpe_div.sv]
module edpe_div #(
    parameter int DIVIDEND_BITS = edpe_pkg::TURN_BITS_DEFAULT + edpe_pkg::ANGLE_BITS,
    parameter int COUNT_BITS    = $clog2(DIVIDEND_BITS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [DIVIDEND_BITS-1:0]          dividend,
    input  logic [edpe_pkg::DIV_BITS-1:0]     divisor,
    input  logic [COUNT_BITS-1:0]             iters,
    output logic                              busy,
    output logic [DIVIDEND_BITS-1:0]          quotient
);

    localparam int DB = edpe_pkg::DIV_BITS;

    logic [COUNT_BITS-1:0]    cnt_reg;
    logic [DB-1:0]            rem_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DB-1:0]            dvs_reg;
    logic [DB:0]              shifted;
    logic [DB+1:0]            diff;
    logic                     fits;

    // one restoring step per cycle, dividend bits are taken from the top
    assign shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !diff[DB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= iters;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[DB-1:0] : shifted[DB-1:0];
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

[rtl/edpe_ctrl.sv]
module edpe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  edpe_pkg::dp_sts_t sts,
    input  logic              div_busy,
    output edpe_pkg::cmd_t    cmd,
    output logic              item_stall
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_DIV1   = 6'b000100,
        S_QUOT   = 6'b001000,
        S_DIV2   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.active_next ? S_PREP : S_FINISH;
                end
            end
            S_PREP:
            begin
                cmd.load_dist = 1'b1;
                cmd.div_first = 1'b1;
                state_next    = S_DIV1;
            end
            S_DIV1:
            begin
                if (!div_busy)
                begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT:
            begin
                cmd.div_second = 1'b1;
                state_next     = S_DIV2;
            end
            S_DIV2:
            begin
                if (!div_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

[rtl/edpe_dp.sv]
module edpe_dp #(
    parameter int TURN_BITS     = edpe_pkg::TURN_BITS_DEFAULT,
    parameter int DIVIDEND_BITS = TURN_BITS + edpe_pkg::ANGLE_BITS,
    parameter int COUNT_BITS    = $clog2(DIVIDEND_BITS + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  edpe_pkg::cmd_t                         cmd,
    output edpe_pkg::dp_sts_t                      sts,
    input  logic                                   cfg_write,
    input  logic [edpe_pkg::RANGE_INDEX_BITS-1:0]  cfg_index,
    input  logic [edpe_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic [edpe_pkg::ANGLE_BITS-1:0]        raw_angle,
    input  logic [edpe_pkg::BUTTON_BITS-1:0]       button_levels,
    output logic                                   div_start,
    output logic [DIVIDEND_BITS-1:0]               div_dividend,
    output logic [edpe_pkg::DIV_BITS-1:0]          div_divisor,
    output logic [COUNT_BITS-1:0]                  div_iters,
    input  logic [DIVIDEND_BITS-1:0]               div_quotient,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [edpe_pkg::SEL_BITS-1:0]          selected_index,
    output logic [edpe_pkg::VALUE_BITS-1:0]        selected_value,
    output logic                                   value_changed,
    output logic [edpe_pkg::VALUE_BITS-1:0]        value_0,
    output logic [edpe_pkg::VALUE_BITS-1:0]        value_1,
    output logic [edpe_pkg::VALUE_BITS-1:0]        value_2,
    output logic [edpe_pkg::VALUE_BITS-1:0]        value_3
);

    localparam int AB   = edpe_pkg::ANGLE_BITS;
    localparam int VB   = edpe_pkg::VALUE_BITS;
    localparam int SB   = edpe_pkg::SEL_BITS;
    localparam int NR   = edpe_pkg::NUM_RANGES;
    localparam int RB   = edpe_pkg::RANGE_INDEX_BITS;
    localparam int DB   = edpe_pkg::DIV_BITS;
    localparam int N    = DIVIDEND_BITS;
    localparam int W    = N + 1;
    localparam int V    = N + 2;
    localparam int DIRW = AB + 2;

    localparam logic [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    logic [edpe_pkg::CFG_BITS-1:0] range_reg [NR];
    logic [VB-1:0]                 pv_reg [NR];
    logic [SB-1:0]                 sel_reg;
    logic [VB-1:0]                 vas_reg;
    logic [AB-1:0]                 start_reg;
    logic [AB-1:0]                 prev_reg;
    logic [TURN_BITS-1:0]          turn_reg;
    logic [VB-1:0]                 last_reg;
    logic [edpe_pkg::BUTTON_BITS-1:0] bmem_reg;
    logic [AB-1:0]                 angle_reg;
    logic [W-1:0]                  dist_reg;
    logic                          out_valid_reg;
    logic [SB-1:0]                 out_sel_reg;
    logic [VB-1:0]                 out_value_reg;
    logic                          out_changed_reg;

    logic [edpe_pkg::BUTTON_BITS-1:0] rising;
    logic [SB-1:0]                 sel_w;
    logic                          setup_w;
    logic                          active_w;
    logic [DIRW-1:0]               dir;
    logic                          turn_dec;
    logic                          turn_inc;
    logic [TURN_BITS-1:0]          turn_adj;

    logic [edpe_pkg::CFG_BITS-1:0] rw;
    logic [VB-1:0]                 lo;
    logic [VB-1:0]                 hi;
    logic [edpe_pkg::SPT_BITS-1:0] spt_raw;
    logic [DB-1:0]                 spt;
    logic [W-1:0]                  dist_calc;
    logic                          dist_neg;
    logic [W-1:0]                  dist_mag;
    logic [V-1:0]                  q_s;
    logic [V-1:0]                  v_sum;
    logic [VB-1:0]                 v_clamped;
    logic                          active_now;
    logic [VB-1:0]                 cur;
    logic                          out_free;

    // button edges, toggles in button order, dial ends editing
    always_comb
    begin
        rising  = button_levels & ~bmem_reg;
        sel_w   = sel_reg;
        setup_w = 1'b0;
        for (int i = 0; i < edpe_pkg::NUM_DISPLAY; i++)
        begin
            if (rising[i])
            begin
                if (sel_w == SB'(i))
                begin
                    sel_w = edpe_pkg::SEL_NONE;
                end
                else
                begin
                    sel_w   = SB'(i);
                    setup_w = 1'b1;
                end
            end
        end
        if (rising[edpe_pkg::DIAL_BIT])
        begin
            sel_w = edpe_pkg::SEL_NONE;
        end
        active_w = (sel_w != edpe_pkg::SEL_NONE);
    end

    // wrap detection against the previous poll
    assign dir      = {2'b00, raw_angle} - {2'b00, prev_reg};
    assign turn_dec = $signed(dir) > $signed(DIRW'(edpe_pkg::HALF_TURN));
    assign turn_inc = $signed(dir) < -$signed(DIRW'(edpe_pkg::HALF_TURN));

    always_comb
    begin
        turn_adj = turn_reg;
        if (turn_dec && turn_reg != TURN_MIN)
        begin
            turn_adj = turn_reg - TURN_BITS'(1);
        end
        else if (turn_inc && turn_reg != TURN_MAX)
        begin
            turn_adj = turn_reg + TURN_BITS'(1);
        end
    end

    // range fields of the edited parameter
    assign rw      = range_reg[sel_reg[RB-1:0]];
    assign lo      = rw[edpe_pkg::LO_LSB +: VB];
    assign hi      = rw[edpe_pkg::HI_LSB +: VB];
    assign spt_raw = rw[edpe_pkg::SPT_LSB +: edpe_pkg::SPT_BITS];

    always_comb
    begin
        if (spt_raw == '0)
        begin
            spt = DB'(1);
        end
        else if (DB'(spt_raw) > DB'(edpe_pkg::FULL_TURN))
        begin
            spt = DB'(edpe_pkg::FULL_TURN);
        end
        else
        begin
            spt = DB'(spt_raw);
        end
    end

    assign dist_calc = {turn_reg[TURN_BITS-1], turn_reg, {AB{1'b0}}}
                     + W'(angle_reg) - W'(start_reg);
    assign dist_neg  = dist_reg[W-1];
    assign dist_mag  = dist_neg ? (~dist_reg + W'(1)) : dist_reg;

    // shared divider: full turn over steps, then distance over step size
    assign div_start = cmd.div_first | cmd.div_second;
    always_comb
    begin
        if (cmd.div_first)
        begin
            div_dividend = {1'b1, {(N-1){1'b0}}};
            div_divisor  = spt;
            div_iters    = COUNT_BITS'(DB);
        end
        else
        begin
            div_dividend = dist_mag[N-1:0];
            div_divisor  = div_quotient[DB-1:0];
            div_iters    = COUNT_BITS'(N);
        end
    end

    // value at selection plus signed step count, then clamp
    always_comb
    begin
        q_s = V'(div_quotient);
        if (dist_neg)
        begin
            q_s = ~q_s + V'(1);
        end
        v_sum = V'(vas_reg) + q_s;
        if ($signed(v_sum) < $signed(V'(lo)))
        begin
            v_clamped = lo;
        end
        else if ($signed(v_sum) > $signed(V'(hi)))
        begin
            v_clamped = hi;
        end
        else
        begin
            v_clamped = v_sum[VB-1:0];
        end
    end

    assign active_now = (sel_reg != edpe_pkg::SEL_NONE);
    assign cur        = active_now ? v_clamped : '0;
    assign out_free   = !out_valid_reg || !result_stall;

    assign sts.active_next = active_w;
    assign sts.out_free    = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NR; i++)
            begin
                range_reg[i] <= edpe_pkg::RANGE_RESET[i];
                pv_reg[i]    <= edpe_pkg::VALUE_RESET[i];
            end
            sel_reg       <= edpe_pkg::SEL_NONE;
            vas_reg       <= '0;
            start_reg     <= '0;
            prev_reg      <= '0;
            turn_reg      <= '0;
            last_reg      <= '0;
            bmem_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                range_reg[cfg_index] <= cfg_data;
            end
            if (cmd.accept)
            begin
                bmem_reg <= button_levels;
                sel_reg  <= sel_w;
                if (setup_w)
                begin
                    start_reg <= raw_angle;
                    vas_reg   <= pv_reg[sel_w[RB-1:0]];
                end
                if (active_w)
                begin
                    prev_reg <= raw_angle;
                    turn_reg <= setup_w ? '0 : turn_adj;
                end
            end
            if (cmd.finish)
            begin
                if (active_now)
                begin
                    pv_reg[sel_reg[RB-1:0]] <= cur;
                    last_reg                <= cur;
                end
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            angle_reg <= raw_angle;
        end
        if (cmd.load_dist)
        begin
            dist_reg <= dist_calc;
        end
        if (cmd.finish)
        begin
            out_sel_reg     <= sel_reg;
            out_value_reg   <= cur;
            out_changed_reg <= active_now && (cur != last_reg);
        end
    end

    assign result_valid   = out_valid_reg;
    assign selected_index = out_sel_reg;
    assign selected_value = out_value_reg;
    assign value_changed  = out_changed_reg;
    assign value_0        = pv_reg[0];
    assign value_1        = pv_reg[1];
    assign value_2        = pv_reg[2];
    assign value_3        = pv_reg[3];

endmodule

[rtl/encoder_dial_parameter_editor.sv]
// sequence: a poll with no parameter edited goes from acceptance straight to the finish state;
//   while editing it passes the prepare, first divide, quotient and second divide states first
// polls: a new poll is taken only after the last result is handed off; the shared radix-2
//   divider makes two runs, of ANGLE_BITS+1 and TURN_BITS+ANGLE_BITS steps, while editing
// reset: asynchronous active low; range words and parameter values take their
//   defaults, editing off, turn count, start and previous angles and button memory cleared
`include "encoder_dial_parameter_editor_defines.svh"

module encoder_dial_parameter_editor #(
    parameter int TURN_BITS = edpe_pkg::TURN_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_write,
    input  logic [edpe_pkg::RANGE_INDEX_BITS-1:0]  cfg_index,
    input  logic [edpe_pkg::CFG_BITS-1:0]          cfg_data,
    // poll transaction
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic [edpe_pkg::ANGLE_BITS-1:0]        raw_angle,
    input  logic [edpe_pkg::BUTTON_BITS-1:0]       button_levels,
    // result transaction
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [edpe_pkg::SEL_BITS-1:0]          selected_index,
    output logic [edpe_pkg::VALUE_BITS-1:0]        selected_value,
    output logic                                   value_changed,
    output logic [edpe_pkg::VALUE_BITS-1:0]        value_0,
    output logic [edpe_pkg::VALUE_BITS-1:0]        value_1,
    output logic [edpe_pkg::VALUE_BITS-1:0]        value_2,
    output logic [edpe_pkg::VALUE_BITS-1:0]        value_3
);

    // dividend holds the unwrapped distance magnitude
    localparam int DIVIDEND_BITS = TURN_BITS + edpe_pkg::ANGLE_BITS;
    localparam int COUNT_BITS    = $clog2(DIVIDEND_BITS + 1);

    edpe_pkg::cmd_t    cmd;
    edpe_pkg::dp_sts_t sts;

    logic                             div_start;
    logic                             div_busy;
    logic [DIVIDEND_BITS-1:0]         div_dividend;
    logic [edpe_pkg::DIV_BITS-1:0]    div_divisor;
    logic [COUNT_BITS-1:0]            div_iters;
    logic [DIVIDEND_BITS-1:0]         div_quotient;

    // sequencer: accept, then while editing prepare distance and two divides, then hand off the result
    edpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .sts        (sts),
        .div_busy   (div_busy),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    // state, button decode, unwrap, clamp and the output register
    edpe_dp #(
        .TURN_BITS     (TURN_BITS),
        .DIVIDEND_BITS (DIVIDEND_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .raw_angle      (raw_angle),
        .button_levels  (button_levels),
        .div_start      (div_start),
        .div_dividend   (div_dividend),
        .div_divisor    (div_divisor),
        .div_iters      (div_iters),
        .div_quotient   (div_quotient),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .selected_index (selected_index),
        .selected_value (selected_value),
        .value_changed  (value_changed),
        .value_0        (value_0),
        .value_1        (value_1),
        .value_2        (value_2),
        .value_3        (value_3)
    );

    // one quotient bit per cycle, shared by both divides
    edpe_div #(
        .DIVIDEND_BITS (DIVIDEND_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // a divide is never launched over one still running
    `EDPE_ASSERT_IMP(a_div_idle_on_start, clk, rst_n, div_start, !div_busy, "divider restarted while busy")

    // an accepted poll keeps the input side stalled while it is worked on
    `EDPE_ASSERT_NXT(a_stall_after_accept, clk, rst_n, item_valid && !item_stall, item_stall, "input not stalled after acceptance")

    // with nothing selected the edited value and change flag stay clear
    `EDPE_ASSERT_IMP(a_none_is_quiet, clk, rst_n, result_valid && (selected_index == edpe_pkg::SEL_NONE), (selected_value == '0) && !value_changed, "result for no selection not clear")

endmodule
